### src/cll_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cll_pkg
// Shared constants, codes and memory request types of the circular list block.
// ----------------------------------------------------------------------------
package cll_pkg;

  localparam int POOL_DEPTH = 256;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

  localparam int CMD_W   = 3;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 9;

  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TO_HEAD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_NEXT     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOCUR  = 2'd3;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } link_req_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [IDX_W-1:0]      raddr;
  } value_req_t;

endpackage
`default_nettype wire

### src/circular_list_with_cursor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_list_with_cursor
// Circular singly linked list in a fixed node pool, with tail and cursor.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (in_cmd, in_value_in) is taken at a rising edge with start
//   high and busy low. busy stays high while the command works on the node
//   memories. Each command yields exactly one result word: out_value_out,
//   out_status and out_element_count, shown for one cycle with out_valid.
//   The receiver cannot stall; results are never held back.
// States passed, from the accepting edge to the cycle out_valid is high:
//   none (answer from idle) for refused commands (empty, full, no cursor)
//   and unknown codes; RD1 for a remove that empties the list; RD1, RD2
//   for cursor moves and a first insert; RD1, WR1 for other removes;
//   RD1, RD2, WR1 for an insert into a non-empty list.
//   busy falls as out_valid rises, so a new command may start in that cycle.
//   The state sequence is set by the single write port of the link memory
//   and its registered read.
// Reset (synchronous, rst_n low) empties the list, the cursor and the free
//   list; node memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module circular_list_with_cursor
  import cll_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output      logic                    busy,
  input  wire logic [CMD_W-1:0]        in_cmd,
  input  wire logic signed [VAL_W-1:0] in_value_in,
  output      logic                    out_valid,
  output      logic signed [VAL_W-1:0] out_value_out,
  output      logic [STAT_W-1:0]       out_status,
  output      logic [COUNT_W-1:0]      out_element_count
);

  link_req_t             link_req;
  value_req_t            value_req;
  logic [IDX_W-1:0]      link_rdata;
  logic [DATA_WIDTH-1:0] value_rdata;

  cll_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_value_in       (in_value_in),
    .out_valid         (out_valid),
    .out_value_out     (out_value_out),
    .out_status        (out_status),
    .out_element_count (out_element_count),
    .link_req          (link_req),
    .value_req         (value_req),
    .link_rdata        (link_rdata),
    .value_rdata       (value_rdata)
  );

  cll_ram #(
    .DEPTH (POOL_DEPTH),
    .WIDTH (IDX_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_req.we),
    .waddr (link_req.waddr),
    .wdata (link_req.wdata),
    .raddr (link_req.raddr),
    .rdata (link_rdata)
  );

  cll_ram #(
    .DEPTH (POOL_DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_value_ram (
    .clk   (clk),
    .we    (value_req.we),
    .waddr (value_req.waddr),
    .wdata (value_req.wdata),
    .raddr (value_req.raddr),
    .rdata (value_rdata)
  );

endmodule
`default_nettype wire

### src/cll_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cll_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cll_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/cll_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cll_ctrl
// Command sequencer: list pointers, free list and read-modify-write of the
// node memories.
// ----------------------------------------------------------------------------
module cll_ctrl
  import cll_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output      logic                     busy,
  input  wire logic [CMD_W-1:0]         in_cmd,
  input  wire logic signed [VAL_W-1:0]  in_value_in,
  output      logic                     out_valid,
  output      logic signed [VAL_W-1:0]  out_value_out,
  output      logic [STAT_W-1:0]        out_status,
  output      logic [COUNT_W-1:0]       out_element_count,
  output      link_req_t                link_req,
  output      value_req_t               value_req,
  input  wire logic [IDX_W-1:0]         link_rdata,
  input  wire logic [DATA_WIDTH-1:0]    value_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_RD1, S_RD2, S_WR1} state_t;

  state_t                   st_r;
  logic [CMD_W-1:0]         op_r;
  logic [DATA_WIDTH-1:0]    val_r;
  logic [IDX_W-1:0]         node_r;
  logic [IDX_W-1:0]         tail_r;
  logic                     nonempty_r;
  logic [IDX_W-1:0]         cursor_r;
  logic [IDX_W-1:0]         prior_r;
  logic                     cv_r;
  logic [CNT_W-1:0]         count_r;
  logic [IDX_W-1:0]         free_head_r;
  logic [CNT_W-1:0]         free_count_r;
  logic [CNT_W-1:0]         nun_r;
  logic                     out_valid_r;
  logic signed [VAL_W-1:0]  out_value_r;
  logic [STAT_W-1:0]        out_status_r;
  logic [COUNT_W-1:0]       out_count_r;

  logic pool_full;
  logic single;
  logic rm_bad;
  logic fix;

  assign pool_full = (free_count_r == '0) && (nun_r == CNT_W'(POOL_DEPTH));
  assign single    = (count_r <= CNT_W'(1));
  assign rm_bad    = !cv_r || (!single && (prior_r == cursor_r));
  assign fix       = cv_r && (prior_r == tail_r) &&
                     ((count_r == CNT_W'(1)) || (prior_r != cursor_r));

  assign busy              = (st_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_value_out     = out_value_r;
  assign out_status        = out_status_r;
  assign out_element_count = out_count_r;

  always_comb begin
    link_req  = '0;
    value_req = '0;
    unique case (st_r)
      S_IDLE: begin
        unique case (in_cmd) inside
          CMD_INS_TAIL, CMD_INS_HEAD: link_req.raddr = free_head_r;
          CMD_TO_HEAD:                link_req.raddr = tail_r;
          default:                    link_req.raddr = cursor_r;
        endcase
        value_req.raddr = cursor_r;
      end
      S_RD1: begin
        unique case (op_r) inside
          CMD_INS_TAIL, CMD_INS_HEAD: link_req.raddr = tail_r;
          CMD_TO_HEAD, CMD_NEXT:      value_req.raddr = link_rdata;
          CMD_REMOVE: begin
            link_req.we = 1'b1;
            if (single) begin
              link_req.waddr = node_r;
              link_req.wdata = free_head_r;
            end else begin
              link_req.waddr = prior_r;
              link_req.wdata = link_rdata;
            end
          end
          default: ;
        endcase
      end
      S_RD2: begin
        if ((op_r == CMD_INS_TAIL) || (op_r == CMD_INS_HEAD)) begin
          link_req.we     = 1'b1;
          link_req.waddr  = node_r;
          link_req.wdata  = nonempty_r ? link_rdata : node_r;
          value_req.we    = 1'b1;
          value_req.waddr = node_r;
          value_req.wdata = val_r;
        end
      end
      S_WR1: begin
        link_req.we = 1'b1;
        if (op_r == CMD_REMOVE) begin
          link_req.waddr = node_r;
          link_req.wdata = free_head_r;
        end else begin
          link_req.waddr = tail_r;
          link_req.wdata = node_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      tail_r       <= '0;
      nonempty_r   <= 1'b0;
      cursor_r     <= '0;
      prior_r      <= '0;
      cv_r         <= 1'b0;
      count_r      <= '0;
      free_head_r  <= '0;
      free_count_r <= '0;
      nun_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (start) begin
            op_r         <= in_cmd;
            val_r        <= DATA_WIDTH'(in_value_in);
            out_value_r  <= '0;
            out_status_r <= ST_OK;
            out_count_r  <= COUNT_W'(count_r);
            unique case (in_cmd) inside
              CMD_INS_TAIL, CMD_INS_HEAD: begin
                if (pool_full) begin
                  out_status_r <= ST_FULL;
                  out_valid_r  <= 1'b1;
                end else begin
                  st_r <= S_RD1;
                end
              end
              CMD_TO_HEAD: begin
                if (!nonempty_r) begin
                  out_status_r <= ST_EMPTY;
                  out_valid_r  <= 1'b1;
                end else begin
                  node_r <= tail_r;
                  st_r   <= S_RD1;
                end
              end
              CMD_NEXT, CMD_REMOVE: begin
                if (!nonempty_r) begin
                  out_status_r <= ST_EMPTY;
                  out_valid_r  <= 1'b1;
                end else if (!cv_r || ((in_cmd == CMD_REMOVE) && rm_bad)) begin
                  out_status_r <= ST_NOCUR;
                  out_valid_r  <= 1'b1;
                end else begin
                  node_r <= cursor_r;
                  st_r   <= S_RD1;
                end
              end
              default: out_valid_r <= 1'b1;
            endcase
          end
        end
        S_RD1: begin
          unique case (op_r) inside
            CMD_INS_TAIL, CMD_INS_HEAD: begin
              if (free_count_r != '0) begin
                node_r       <= free_head_r;
                free_head_r  <= link_rdata;
                free_count_r <= free_count_r - CNT_W'(1);
              end else begin
                node_r <= nun_r[IDX_W-1:0];
                nun_r  <= nun_r + CNT_W'(1);
              end
              st_r <= S_RD2;
            end
            CMD_TO_HEAD, CMD_NEXT: begin
              prior_r  <= node_r;
              cursor_r <= link_rdata;
              cv_r     <= 1'b1;
              st_r     <= S_RD2;
            end
            CMD_REMOVE: begin
              out_value_r <= VAL_W'(value_rdata);
              if (single) begin
                nonempty_r   <= 1'b0;
                cv_r         <= 1'b0;
                tail_r       <= '0;
                cursor_r     <= '0;
                prior_r      <= '0;
                free_head_r  <= node_r;
                free_count_r <= free_count_r + CNT_W'(1);
                count_r      <= count_r - CNT_W'(1);
                out_count_r  <= COUNT_W'(count_r - CNT_W'(1));
                out_valid_r  <= 1'b1;
                st_r         <= S_IDLE;
              end else begin
                if (node_r == tail_r) begin
                  tail_r <= prior_r;
                end
                cursor_r <= prior_r;
                st_r     <= S_WR1;
              end
            end
            default: st_r <= S_IDLE;
          endcase
        end
        S_RD2: begin
          if ((op_r == CMD_TO_HEAD) || (op_r == CMD_NEXT)) begin
            out_value_r <= VAL_W'(value_rdata);
            out_valid_r <= 1'b1;
            st_r        <= S_IDLE;
          end else if (!nonempty_r) begin
            tail_r      <= node_r;
            nonempty_r  <= 1'b1;
            count_r     <= count_r + CNT_W'(1);
            out_count_r <= COUNT_W'(count_r + CNT_W'(1));
            out_valid_r <= 1'b1;
            st_r        <= S_IDLE;
          end else begin
            st_r <= S_WR1;
          end
        end
        S_WR1: begin
          if (op_r == CMD_REMOVE) begin
            free_head_r  <= node_r;
            free_count_r <= free_count_r + CNT_W'(1);
            count_r      <= count_r - CNT_W'(1);
            out_count_r  <= COUNT_W'(count_r - CNT_W'(1));
          end else begin
            if (fix) begin
              prior_r <= node_r;
            end
            if (op_r == CMD_INS_TAIL) begin
              tail_r <= node_r;
            end
            count_r     <= count_r + CNT_W'(1);
            out_count_r <= COUNT_W'(count_r + CNT_W'(1));
          end
          out_valid_r <= 1'b1;
          st_r        <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sim/circular_list_with_cursor_tb.sv
// ----------------------------------------------------------------------------
// circular_list_with_cursor_tb
// Self-checking bench for the circular list block. A queue of command words
// (directed corner cases, then random traffic, a pool fill and a full drain)
// feeds a clocked driver with random sender gaps. A clocked monitor compares
// every result word against a cycle-free model of the list, free list and
// cursor.
// ----------------------------------------------------------------------------
module circular_list_with_cursor_tb;
  import cll_pkg::*;

  localparam logic [CMD_W-1:0] CMD_BAD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_BAD_LAST  = 3'd7;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
    int                      idle_pct;
  } cmd_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [STAT_W-1:0]       status;
    logic [COUNT_W-1:0]      count;
  } result_word_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic [CMD_W-1:0]        in_cmd = '0;
  logic signed [VAL_W-1:0] in_value_in = '0;
  logic                    busy;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_value_out;
  logic [STAT_W-1:0]       out_status;
  logic [COUNT_W-1:0]      out_element_count;

  circular_list_with_cursor DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_value_in(in_value_in),
    .out_valid(out_valid), .out_value_out(out_value_out),
    .out_status(out_status), .out_element_count(out_element_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // list model
  logic [DATA_WIDTH-1:0] m_value [POOL_DEPTH];
  logic [IDX_W-1:0]      m_link  [POOL_DEPTH];
  logic [IDX_W-1:0]      m_tail, m_cur, m_prev, m_free_head;
  logic                  m_nonempty, m_cur_valid;
  logic [CNT_W-1:0]      m_count, m_free_count, m_fresh_next;

  cmd_word_t    pending_words[$];
  result_word_t expected_results[$];
  cmd_word_t    cur_word;

  int words_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int errors = 0;
  int idle_cycles = 0;
  int peak_count = 0;
  int status_hits[4] = '{0, 0, 0, 0};

  task automatic clear_list_model();
    for (int i = 0; i < POOL_DEPTH; i++) begin
      m_value[i] = '0;
      m_link[i]  = '0;
    end
    m_tail = '0; m_cur = '0; m_prev = '0; m_free_head = '0;
    m_nonempty = 1'b0; m_cur_valid = 1'b0;
    m_count = '0; m_free_count = '0; m_fresh_next = '0;
  endtask

  task automatic list_insert(input logic [DATA_WIDTH-1:0] v, input bit at_tail,
                             output logic [STAT_W-1:0] st);
    logic [IDX_W-1:0] n, t;
    bit fix;
    st = ST_OK;
    if (m_free_count > 0) begin
      n = m_free_head;
      m_free_head = m_link[n];
      m_free_count--;
    end else if (m_fresh_next < POOL_DEPTH) begin
      n = m_fresh_next[IDX_W-1:0];
      m_fresh_next++;
    end else begin
      st = ST_FULL;
      return;
    end
    m_value[n] = v;
    if (!m_nonempty) begin
      m_link[n] = n;
      m_tail = n;
      m_nonempty = 1'b1;
    end else begin
      t = m_tail;
      fix = m_cur_valid && m_prev == t && (m_count == 1 || m_prev != m_cur);
      m_link[n] = m_link[t];
      m_link[t] = n;
      if (fix) m_prev = n;
      if (at_tail) m_tail = n;
    end
    m_count++;
  endtask

  task automatic list_apply(input cmd_word_t w, output result_word_t r);
    logic [IDX_W-1:0] rn, pn;
    logic [STAT_W-1:0] st;
    logic [DATA_WIDTH-1:0] data;
    st = ST_OK;
    data = '0;
    case (w.cmd)
      CMD_INS_TAIL, CMD_INS_HEAD: begin
        list_insert(w.value, w.cmd == CMD_INS_TAIL, st);
      end
      CMD_TO_HEAD: begin
        if (!m_nonempty) begin
          st = ST_EMPTY;
        end else begin
          m_prev = m_tail;
          m_cur = m_link[m_prev];
          m_cur_valid = 1'b1;
          data = m_value[m_cur];
        end
      end
      CMD_NEXT: begin
        if (!m_nonempty) begin
          st = ST_EMPTY;
        end else if (!m_cur_valid) begin
          st = ST_NOCUR;
        end else begin
          m_prev = m_cur;
          m_cur = m_link[m_prev];
          data = m_value[m_cur];
        end
      end
      CMD_REMOVE: begin
        if (!m_nonempty) begin
          st = ST_EMPTY;
        end else if (!m_cur_valid || (m_count > 1 && m_prev == m_cur)) begin
          st = ST_NOCUR;
        end else begin
          rn = m_cur;
          pn = m_prev;
          data = m_value[rn];
          if (m_count <= 1) begin
            m_nonempty = 1'b0; m_cur_valid = 1'b0;
            m_tail = '0; m_cur = '0; m_prev = '0;
          end else begin
            if (rn == m_tail) m_tail = pn;
            m_link[pn] = m_link[rn];
            m_cur = pn;
          end
          m_link[rn] = m_free_head;
          m_free_head = rn;
          m_free_count++;
          m_count--;
        end
      end
      default: begin
      end
    endcase
    r.value = data;
    r.status = st;
    r.count = m_count;
  endtask

  function automatic logic signed [VAL_W-1:0] random_value();
    case ($urandom_range(7))
      0: return {1'b1, {(VAL_W-1){1'b0}}};
      1: return {1'b0, {(VAL_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(input logic [CMD_W-1:0] c, input logic signed [VAL_W-1:0] v,
                           input int idle);
    cmd_word_t w;
    w.cmd = c;
    w.value = v;
    w.idle_pct = idle;
    pending_words.push_back(w);
  endtask

  task automatic push_random(input int p_ins, input int p_next, input int p_rem,
                             input int idle);
    int r;
    logic [CMD_W-1:0] c;
    r = $urandom_range(99);
    if (r < p_ins) c = $urandom_range(1) ? CMD_INS_TAIL : CMD_INS_HEAD;
    else if (r < p_ins + p_next) c = CMD_NEXT;
    else if (r < p_ins + p_next + p_rem) c = CMD_REMOVE;
    else if (r < 97) c = CMD_TO_HEAD;
    else c = CMD_W'($urandom_range(CMD_BAD_LAST, CMD_BAD_FIRST));
    push_word(c, random_value(), idle);
  endtask

  // driver
  always @(posedge clk) begin
    result_word_t r;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        list_apply(cur_word, r);
        expected_results.push_back(r);
        words_sent++;
        if (m_count > peak_count) peak_count = m_count;
      end
      if (!start || !busy) begin
        if (pending_words.size() > 0 &&
            $urandom_range(99) >= pending_words[0].idle_pct) begin
          cur_word = pending_words.pop_front();
          in_cmd <= cur_word.cmd;
          in_value_in <= cur_word.value;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    result_word_t want;
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid) begin
        results_seen++;
        status_hits[out_status]++;
        if (expected_results.size() == 0) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("result word with none expected: value %0d status %0d count %0d",
                     out_value_out, out_status, out_element_count);
        end else begin
          want = expected_results.pop_front();
          if (out_value_out !== want.value || out_status !== want.status ||
              out_element_count !== want.count) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
              $display("word %0d: expected value %0d status %0d count %0d, got %0d %0d %0d",
                       results_seen, want.value, want.status, want.count,
                       out_value_out, out_status, out_element_count);
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
        $display("circular_list_with_cursor_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    clear_list_model();

    // directed corners
    push_word(CMD_REMOVE, '0, 0);
    push_word(CMD_NEXT, '0, 0);
    push_word(CMD_TO_HEAD, '0, 0);
    for (int c = CMD_BAD_FIRST; c <= CMD_BAD_LAST; c++) push_word(CMD_W'(c), '1, 0);
    push_word(CMD_INS_TAIL, {1'b0, {(VAL_W-1){1'b1}}}, 0);
    push_word(CMD_NEXT, '0, 0);
    push_word(CMD_REMOVE, '0, 0);
    push_word(CMD_TO_HEAD, '0, 0);
    push_word(CMD_INS_TAIL, {1'b1, {(VAL_W-1){1'b0}}}, 0);
    push_word(CMD_INS_HEAD, '0, 0);
    push_word(CMD_INS_HEAD, '1, 0);
    push_word(CMD_NEXT, '0, 0);
    push_word(CMD_NEXT, '0, 0);
    push_word(CMD_REMOVE, '0, 0);
    push_word(CMD_REMOVE, '0, 0);
    push_word(CMD_NEXT, '0, 0);
    push_word(CMD_INS_TAIL, 32'h5555_AAAA, 0);
    push_word(CMD_INS_HEAD, 32'hAAAA_5555, 0);
    push_word(CMD_TO_HEAD, '0, 0);
    push_word(CMD_REMOVE, '0, 0);
    push_word(CMD_NEXT, '0, 0);
    push_word(CMD_REMOVE, '0, 0);

    // random mix, slow sender
    for (int i = 0; i < 280; i++) push_random(40, 30, 25, 51);

    // fill the pool past full, then reuse a freed node
    for (int i = 0; i < 262; i++)
      push_word($urandom_range(1) ? CMD_INS_TAIL : CMD_INS_HEAD, random_value(), 0);
    push_word(CMD_TO_HEAD, '0, 0);
    push_word(CMD_NEXT, '0, 0);
    push_word(CMD_REMOVE, '0, 0);
    push_word(CMD_INS_TAIL, random_value(), 0);
    push_word(CMD_INS_HEAD, random_value(), 0);

    // traversal heavy
    for (int i = 0; i < 230; i++) push_random(15, 40, 42, 20);

    // drain: move then remove, until empty
    push_word(CMD_TO_HEAD, '0, 51);
    for (int i = 0; i < 270; i++) begin
      push_word($urandom_range(9) == 0 ? CMD_TO_HEAD : CMD_NEXT, random_value(),
                i < 135 ? 51 : 0);
      push_word(CMD_REMOVE, random_value(), i < 135 ? 51 : 0);
    end
    push_word(CMD_INS_HEAD, random_value(), 20);
    push_word(CMD_TO_HEAD, '0, 20);
    push_word(CMD_REMOVE, '0, 20);
    push_word(CMD_NEXT, '0, 20);
    push_word(CMD_REMOVE, '0, 20);
    push_word(CMD_TO_HEAD, '0, 20);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    errors += expected_results.size();

    $display("ran %0d command words, checked %0d result words, peak length %0d",
             words_sent, results_seen, peak_count);
    $display("status ok %0d, empty %0d, full %0d, no cursor %0d; %0d mismatches",
             status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_FULL],
             status_hits[ST_NOCUR], mismatches);
    if (errors == 0) begin
      $display("circular_list_with_cursor_tb: PASS");
    end else begin
      $display("circular_list_with_cursor_tb: FAIL");
    end
    $finish;
  end

endmodule

### circular_list_with_cursor.f
src/cll_pkg.sv
src/cll_ram.sv
src/cll_ctrl.sv
src/circular_list_with_cursor.sv
sim/circular_list_with_cursor_tb.sv
